// ===== rtl/ggsf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ggsf_pkg - shared types and constants of the glow splat frame store
// Operation and register codes, sequencer states, multiplier widths and the
// fractional power-of-two table used for the gaussian weight.
// ============================================================================
package ggsf_pkg;

    // Operation codes carried in func
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_SPLAT = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_THRESHOLD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FALLOFF_RATE     = 4'd1;

    localparam logic [11:0] THRESHOLD_RESET = 12'd61;
    localparam logic [9:0]  FALLOFF_RESET   = 10'd320;

    // log2(e) in Q.12 and 1.0 in Q1.12
    localparam logic [12:0] LOG2E_Q12 = 13'd5909;
    localparam logic [12:0] ONE_Q12   = 13'd4096;

    // Shared multiplier operand widths: squared distance times exponent scale
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 23;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int PIXEL_W = 24;

    // round(65536 * 2^(-f/16))
    localparam logic [16:0] POW2_FRAC [16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549,
        17'd55109, 17'd52773, 17'd50535, 17'd48393,
        17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_K,
        S_DX,
        S_DY,
        S_U,
        S_E,
        S_W,
        S_T,
        S_CR,
        S_CG,
        S_CB,
        S_WR,
        S_DONE
    } state_t;

    // q holds the exponent in sixteenths of an octave; result is Q1.16
    function automatic logic [16:0] exp_lookup(input logic [17:0] q);
        logic [16:0] frac;
        begin
            frac = POW2_FRAC[q[3:0]];
            if (q[17:8] != 10'd0)
            begin
                return 17'd0;
            end
            return frac >> q[7:4];
        end
    endfunction

endpackage

// ===== rtl/ggsf_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ggsf_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module ggsf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ggsf_mul.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ggsf_mul - shared unsigned multiplier
// Registered product; every multiply of the splat sequencer goes through here.
// ============================================================================
module ggsf_mul (
    input  logic                        clk,
    input  logic [ggsf_pkg::MUL_A_W-1:0] a,
    input  logic [ggsf_pkg::MUL_B_W-1:0] b,
    output logic [ggsf_pkg::MUL_P_W-1:0] p
);
    import ggsf_pkg::*;

    logic [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/gaussian_glow_splat_framebuffer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gaussian_glow_splat_framebuffer - additive gaussian glow frame store
// GRID_SIDE x GRID_SIDE RGB store; clear, splat and read requests, one
// response per request. Weights use one shared multiplier and an exp table.
// ============================================================================
// Sequence: clear and unused codes go straight to the response, a read
//   first reads the RAM, a splat walks every pixel (colour steps only if touched).
// Throughput: one request at a time; the splat time is set by the per-pixel
//   walk through the single shared multiplier (up to seven products a pixel).
// A new request is taken while the previous response still waits.
// Reset: thresholds load 61 and 320, per-pixel valid bits clear at once so
//   the whole store reads black; there is no clearing pass.
module gaussian_glow_splat_framebuffer #(
    parameter int GRID_SIDE = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [1:0]                        func,
    input  logic signed [12:0]                center_x,
    input  logic signed [12:0]                center_y,
    input  logic [23:0]                       color_rgb,
    input  logic [12:0]                       power,
    input  logic [5:0]                        pixel_index,

    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [23:0]                       pixel_rgb,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ggsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ggsf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ggsf_pkg::*;

    localparam int PIXEL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int AW          = $clog2(PIXEL_COUNT);
    localparam int XW          = $clog2(GRID_SIDE);
    localparam logic [XW-1:0] LAST_POS = XW'(GRID_SIDE - 1);

    state_t state_reg, state_next;

    // request payload held for the duration of a splat
    logic signed [12:0] cx_reg, cx_next;
    logic signed [12:0] cy_reg, cy_next;
    logic [23:0]        color_reg, color_next;
    logic [12:0]        power_reg, power_next;

    logic [AW-1:0]      addr_reg, addr_next;
    logic [XW-1:0]      px_reg, px_next;
    logic [XW-1:0]      py_reg, py_next;
    logic               hit_reg, hit_next;

    logic [22:0]        k_reg, k_next;
    logic [25:0]        d2_reg, d2_next;
    logic [16:0]        e_reg, e_next;
    logic [12:0]        s_reg, s_next;
    logic [7:0]         gain_r_reg, gain_r_next;
    logic [7:0]         gain_g_reg, gain_g_next;
    logic [23:0]        res_reg, res_next;

    logic [PIXEL_COUNT-1:0] valid_reg, valid_next;

    logic [11:0]        thr_reg;
    logic [9:0]         fall_reg;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [23:0]        pixel_rgb_reg, pixel_rgb_next;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    // frame RAM
    logic               ram_we;
    logic [23:0]        ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [23:0]        ram_rdata;

    logic               req_fire;
    logic               read_in_range;
    logic signed [14:0] dx, dy;
    logic [12:0]        dx_mag, dy_mag;
    logic [12:0]        weight;
    logic [23:0]        base;
    logic [7:0]         gain_b;
    logic [8:0]         sum_r, sum_g, sum_b;
    logic               rsp_free;

    ggsf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ggsf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (PIXEL_COUNT)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign pixel_rgb = pixel_rgb_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign read_in_range = (32'(pixel_index) < PIXEL_COUNT);

    // offsets of the pixel from the centre in Q.8
    assign dx = 15'({px_reg, 8'h00}) - {{2{cx_reg[12]}}, cx_reg};
    assign dy = 15'({py_reg, 8'h00}) - {{2{cy_reg[12]}}, cy_reg};
    assign dx_mag = dx[14] ? 13'(-dx) : 13'(dx);
    assign dy_mag = dy[14] ? 13'(-dy) : 13'(dy);

    // weight in Q1.12 from power * exp term
    assign weight = mul_p[28:16];

    // a pixel never written since the last clear reads black
    assign base   = valid_reg[addr_reg] ? ram_rdata : 24'd0;
    assign gain_b = mul_p[19:12];
    assign sum_r  = {1'b0, base[23:16]} + {1'b0, gain_r_reg};
    assign sum_g  = {1'b0, base[15:8]}  + {1'b0, gain_g_reg};
    assign sum_b  = {1'b0, base[7:0]}   + {1'b0, gain_b};
    assign ram_wdata = {sum_r[8] ? 8'hFF : sum_r[7:0],
                        sum_g[8] ? 8'hFF : sum_g[7:0],
                        sum_b[8] ? 8'hFF : sum_b[7:0]};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RESET;
            fall_reg <= FALLOFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WEIGHT_THRESHOLD: thr_reg  <= cfg_data[11:0];
                REG_FALLOFF_RATE:     fall_reg <= cfg_data[9:0];
                default:              ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        color_reg     <= color_next;
        power_reg     <= power_next;
        addr_reg      <= addr_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        hit_reg       <= hit_next;
        k_reg         <= k_next;
        d2_reg        <= d2_next;
        e_reg         <= e_next;
        s_reg         <= s_next;
        gain_r_reg    <= gain_r_next;
        gain_g_reg    <= gain_g_next;
        res_reg       <= res_next;
        pixel_rgb_reg <= pixel_rgb_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        color_next     = color_reg;
        power_next     = power_reg;
        addr_next      = addr_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        hit_next       = hit_reg;
        k_next         = k_reg;
        d2_next        = d2_reg;
        e_next         = e_reg;
        s_next         = s_reg;
        gain_r_next    = gain_r_reg;
        gain_g_next    = gain_g_reg;
        res_next       = res_reg;
        valid_next     = valid_reg;
        pixel_rgb_next = pixel_rgb_reg;
        rsp_valid_next = rsp_valid_reg;
        mul_a          = '0;
        mul_b          = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg;

        // drop the response once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_next   = 24'd0;
                    cx_next    = center_x;
                    cy_next    = center_y;
                    color_next = color_rgb;
                    power_next = power;
                    addr_next  = '0;
                    px_next    = '0;
                    py_next    = '0;
                    case (func)
                        FUNC_CLEAR:
                        begin
                            valid_next = '0;
                            state_next = S_DONE;
                        end
                        FUNC_SPLAT:
                        begin
                            state_next = S_K;
                        end
                        FUNC_READ:
                        begin
                            addr_next  = AW'(pixel_index);
                            hit_next   = read_in_range;
                            ram_re     = read_in_range;
                            ram_raddr  = AW'(pixel_index);
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                res_next   = (hit_reg && valid_reg[addr_reg]) ? ram_rdata : 24'd0;
                state_next = S_DONE;
            end

            // exponent scale falloff * log2(e), once per splat
            S_K:
            begin
                mul_a      = MUL_A_W'(fall_reg);
                mul_b      = MUL_B_W'(LOG2E_Q12);
                state_next = S_DX;
            end

            // fetch the pixel and square the column offset
            S_DX:
            begin
                if (addr_reg == '0)
                begin
                    k_next = mul_p[22:0];
                end
                ram_re     = 1'b1;
                ram_raddr  = addr_reg;
                mul_a      = MUL_A_W'(dx_mag);
                mul_b      = MUL_B_W'(dx_mag);
                state_next = S_DY;
            end

            S_DY:
            begin
                d2_next    = mul_p[25:0];
                mul_a      = MUL_A_W'(dy_mag);
                mul_b      = MUL_B_W'(dy_mag);
                state_next = S_U;
            end

            // exponent in octaves, Q.36
            S_U:
            begin
                mul_a      = MUL_A_W'(d2_reg) + MUL_A_W'(mul_p[25:0]);
                mul_b      = k_reg;
                state_next = S_E;
            end

            S_E:
            begin
                e_next     = exp_lookup(mul_p[49:32]);
                state_next = S_W;
            end

            S_W:
            begin
                mul_a      = MUL_A_W'(e_reg);
                mul_b      = MUL_B_W'(power_reg);
                state_next = S_T;
            end

            // touch only pixels strictly above the threshold; remember the
            // outcome for the write-back step
            S_T:
            begin
                s_next   = (weight > ONE_Q12) ? ONE_Q12 : weight;
                hit_next = (weight > {1'b0, thr_reg});
                if (weight > {1'b0, thr_reg})
                begin
                    state_next = S_CR;
                end
                else
                begin
                    state_next = S_WR;
                end
            end

            S_CR:
            begin
                mul_a      = MUL_A_W'(s_reg);
                mul_b      = MUL_B_W'(color_reg[23:16]);
                state_next = S_CG;
            end

            S_CG:
            begin
                gain_r_next = mul_p[19:12];
                mul_a       = MUL_A_W'(s_reg);
                mul_b       = MUL_B_W'(color_reg[15:8]);
                state_next  = S_CB;
            end

            S_CB:
            begin
                gain_g_next = mul_p[19:12];
                mul_a       = MUL_A_W'(s_reg);
                mul_b       = MUL_B_W'(color_reg[7:0]);
                state_next  = S_WR;
            end

            // write back a touched pixel, then advance to the next one
            S_WR:
            begin
                ram_we = hit_reg;
                if (ram_we)
                begin
                    valid_next[addr_reg] = 1'b1;
                end
                addr_next  = addr_reg + AW'(1);
                state_next = S_DX;
                if (px_reg == LAST_POS)
                begin
                    px_next = '0;
                    py_next = py_reg + XW'(1);
                    if (py_reg == LAST_POS)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    px_next = px_reg + XW'(1);
                end
            end

            // hand the result to the response register when it frees up
            S_DONE:
            begin
                if (rsp_free)
                begin
                    pixel_rgb_next = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_splat_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && func == FUNC_SPLAT |=> state_reg == S_K)
        else $error("splat request did not start the sequencer");

    a_clear_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && func == FUNC_CLEAR |=> valid_reg == '0)
        else $error("clear request left pixels marked written");

    a_addr_track: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DX |->
            32'(addr_reg) == 32'(py_reg) * GRID_SIDE + 32'(px_reg))
        else $error("pixel address out of step with row and column");

    a_write_touch: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_WR && $past(state_reg) == S_CB)
        else $error("frame write without a completed channel blend");

endmodule

// ===== tb/tb_gaussian_glow_splat_framebuffer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_gaussian_glow_splat_framebuffer - self-checking bench for the glow store
// Drives clear, splat, read and unused-code requests with random gaps and
// response stalls. A local frame store and weight calculation predict every
// response, and the register port is exercised between traffic phases.
// ============================================================================
module tb_gaussian_glow_splat_framebuffer;

    import ggsf_pkg::*;

    localparam int          GRID         = 8;
    localparam int          PIXELS       = GRID * GRID;
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    localparam longint      LOG2E_SCALE  = 64'd5909;
    localparam longint      FULL_STRENGTH = 64'd4096;
    localparam int          CYCLE_LIMIT  = 2_000_000;

    // One request as it crosses the request channel
    typedef struct packed {
        logic [1:0]         op;
        logic signed [12:0] cx;
        logic signed [12:0] cy;
        logic [23:0]        rgb;
        logic [12:0]        pw;
        logic [5:0]         idx;
    } glow_req_t;

    logic                    clk;
    logic                    rst_n;

    logic                    req_valid;
    logic                    req_ready;
    logic [1:0]              func;
    logic signed [12:0]      center_x;
    logic signed [12:0]      center_y;
    logic [23:0]             color_rgb;
    logic [12:0]             power;
    logic [5:0]              pixel_index;

    logic                    rsp_valid;
    logic                    rsp_ready;
    logic [23:0]             pixel_rgb;

    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Predicted state: frame contents and the two registers
    logic [23:0]             frame_model [PIXELS];
    logic [11:0]             threshold_model;
    logic [9:0]              falloff_model;

    // Responses still owed by the block, oldest first
    logic [23:0]             expected_pixels [$];
    logic [23:0]             want_pixel;

    int                      mismatch_count;
    int                      responses_checked;
    int                      splats_sent;
    int                      reads_sent;
    int                      clears_sent;
    int                      unused_sent;
    int                      reg_writes;
    int                      cycle_count;

    // Receiver control: a forced hold-off and the current random run length
    int                      rsp_hold_left;
    int                      rsp_run_left;

    gaussian_glow_splat_framebuffer #(
        .GRID_SIDE (GRID)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .func        (func),
        .center_x    (center_x),
        .center_y    (center_y),
        .color_rgb   (color_rgb),
        .power       (power),
        .pixel_index (pixel_index),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .pixel_rgb   (pixel_rgb),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // 2^(-f/16) in Q1.16, rounded
    function automatic longint exp2_frac(input logic [3:0] f);
        case (f)
            4'd0:  return 65536;
            4'd1:  return 62757;
            4'd2:  return 60097;
            4'd3:  return 57549;
            4'd4:  return 55109;
            4'd5:  return 52773;
            4'd6:  return 50535;
            4'd7:  return 48393;
            4'd8:  return 46341;
            4'd9:  return 44376;
            4'd10: return 42495;
            4'd11: return 40693;
            4'd12: return 38968;
            4'd13: return 37316;
            4'd14: return 35734;
            default: return 34219;
        endcase
    endfunction

    // Add a scaled colour channel, saturating at full scale
    function automatic logic [7:0] blend_channel(input logic [7:0] base,
                                                 input logic [7:0] col,
                                                 input longint strength);
        longint sum;
        sum = longint'(base) + ((longint'(col) * strength) >> 12);
        return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    // Walk every pixel, weigh it against the gaussian and blend where it passes
    function automatic void splat_frame(input glow_req_t r);
        longint dx;
        longint dy;
        longint d2;
        longint octaves;
        longint q;
        longint e;
        longint wgt;
        longint strength;
        logic [23:0] old_px;
        for (int py = 0; py < GRID; py++)
        begin
            for (int px = 0; px < GRID; px++)
            begin
                dx      = longint'(px) * 256 - longint'($signed(r.cx));
                dy      = longint'(py) * 256 - longint'($signed(r.cy));
                d2      = dx * dx + dy * dy;
                // exponent in octaves, Q.36; keep sixteenths of an octave
                octaves = d2 * longint'(falloff_model) * LOG2E_SCALE;
                q       = octaves >>> 32;
                e       = ((q >>> 4) < 16) ? (exp2_frac(q[3:0]) >>> (q >>> 4)) : 0;
                wgt     = (longint'(r.pw) * e) >>> 16;
                if (wgt > longint'(threshold_model))
                begin
                    strength = (wgt > FULL_STRENGTH) ? FULL_STRENGTH : wgt;
                    old_px   = frame_model[py * GRID + px];
                    frame_model[py * GRID + px] = {
                        blend_channel(old_px[23:16], r.rgb[23:16], strength),
                        blend_channel(old_px[15:8],  r.rgb[15:8],  strength),
                        blend_channel(old_px[7:0],   r.rgb[7:0],   strength)
                    };
                end
            end
        end
    endfunction

    // Apply one request to the frame store copy and return the response it owes
    function automatic logic [23:0] apply_to_frame_model(input glow_req_t r);
        logic [23:0] rsp;
        rsp = 24'd0;
        case (r.op)
            FUNC_CLEAR:
            begin
                for (int i = 0; i < PIXELS; i++)
                begin
                    frame_model[i] = 24'd0;
                end
            end
            FUNC_SPLAT:
            begin
                splat_frame(r);
            end
            FUNC_READ:
            begin
                if (int'(r.idx) < PIXELS)
                begin
                    rsp = frame_model[r.idx];
                end
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Request construction
    // ------------------------------------------------------------------------

    function automatic glow_req_t make_request(input logic [1:0] op, input int cx,
                                               input int cy, input logic [23:0] rgb,
                                               input int pw, input int idx);
        glow_req_t r;
        r.op  = op;
        r.cx  = 13'(cx);
        r.cy  = 13'(cy);
        r.rgb = rgb;
        r.pw  = 13'(pw);
        r.idx = 6'(idx);
        return r;
    endfunction

    // A read with junk in every field it ignores
    function automatic glow_req_t read_request(input int idx);
        return make_request(FUNC_READ, $urandom, $urandom, 24'($urandom), $urandom, idx);
    endfunction

    // Splats land mostly near the grid so they touch pixels; clears come often
    // enough that the store does not sit saturated
    function automatic glow_req_t random_request();
        glow_req_t r;
        int        roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            r.op = FUNC_SPLAT;
        else if (roll < 82)
            r.op = FUNC_READ;
        else if (roll < 92)
            r.op = FUNC_CLEAR;
        else
            r.op = FUNC_UNUSED;
        if ($urandom_range(0, 6) == 0)
        begin
            r.cx = 13'($urandom);
            r.cy = 13'($urandom);
        end
        else
        begin
            r.cx = 13'(int'($urandom_range(0, 2815)) - 512);
            r.cy = 13'(int'($urandom_range(0, 2815)) - 512);
        end
        roll = $urandom_range(0, 99);
        if (roll < 70)
            r.pw = 13'($urandom_range(0, 4096));
        else if (roll < 90)
            r.pw = 13'($urandom_range(0, 600));
        else
            r.pw = 13'($urandom_range(4097, 8191));
        r.rgb = 24'($urandom);
        r.idx = 6'($urandom_range(0, 63));
        return r;
    endfunction

    // Mostly back to back or short gaps, now and then a long pause
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offer one request, hold it until accepted, then record what it owes.
    // With gap zero the valid stays up so the next request follows directly.
    task automatic send_request(input glow_req_t r, input int gap);
        @(negedge clk);
        req_valid   <= 1'b1;
        func        <= r.op;
        center_x    <= r.cx;
        center_y    <= r.cy;
        color_rgb   <= r.rgb;
        power       <= r.pw;
        pixel_index <= r.idx;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_pixels.push_back(apply_to_frame_model(r));
        case (r.op)
            FUNC_CLEAR: clears_sent++;
            FUNC_SPLAT: splats_sent++;
            FUNC_READ:  reads_sent++;
            default:    unused_sent++;
        endcase
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Write one register; only called with the block idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            REG_WEIGHT_THRESHOLD: threshold_model = data;
            REG_FALLOFF_RATE:     falloff_model   = data[9:0];
            default:              ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and hold off until every owed response has come back
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Load both registers; the falloff write carries junk in its spare bits
    task automatic load_settings(input logic [11:0] threshold, input logic [9:0] falloff);
        wait_drained();
        write_reg(REG_WEIGHT_THRESHOLD, threshold);
        write_reg(REG_FALLOFF_RATE, {2'($urandom), falloff});
    endtask

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------

    // Random ready: alternate runs of accepting and stalling. A forced hold-off
    // from a test overrides the random pattern and counts down here.
    initial
    begin
        rsp_ready    = 1'b0;
        rsp_run_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rsp_hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_hold_left--;
            end
            else if (rsp_run_left > 0)
            begin
                rsp_run_left--;
            end
            else if (rsp_ready)
            begin
                rsp_ready    <= 1'b0;
                rsp_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                           : $urandom_range(0, 2);
            end
            else
            begin
                rsp_ready    <= 1'b1;
                rsp_run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(0, 20);
            end
        end
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: response with no request owed: expected none, got %06h",
                         $time, pixel_rgb);
                mismatch_count++;
            end
            else
            begin
                want_pixel = expected_pixels.pop_front();
                responses_checked++;
                if (pixel_rgb !== want_pixel)
                begin
                    $display("%0t: pixel_rgb mismatch: expected %06h, got %06h",
                             $time, want_pixel, pixel_rgb);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d responses still owed",
                     $time, cycle_count, expected_pixels.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The store must read black straight out of reset
    task automatic test_reset_state();
        send_request(read_request(0), pick_gap());
        send_request(read_request(63), pick_gap());
        send_request(read_request(36), pick_gap());
    endtask

    // Every operation and the corner cases, under the reset register values
    task automatic test_directed_ops();
        send_request(make_request(FUNC_CLEAR, $urandom, $urandom, 24'($urandom),
                                  $urandom, $urandom), 0);
        // full power white, centred between the four middle pixels
        send_request(make_request(FUNC_SPLAT, 896, 896, 24'hFFFFFF, 4096, 0), 0);
        send_request(read_request(27), 0);
        send_request(read_request(28), 1);
        send_request(read_request(0), 0);
        send_request(read_request(63), 2);
        // power above one on the corner pixel: weight test uses it, blend caps
        send_request(make_request(FUNC_SPLAT, 0, 0, 24'hFF0000, 8191, 63), 0);
        send_request(read_request(0), 0);
        send_request(read_request(1), 0);
        send_request(read_request(9), 0);
        // zero power touches nothing
        send_request(make_request(FUNC_SPLAT, 1024, 1024, 24'hFFFFFF, 0, 5), 0);
        send_request(read_request(36), 0);
        // centres at both extremes of the signed range
        send_request(make_request(FUNC_SPLAT, -4096, -4096, 24'hFFFFFF, 4096, 0), 0);
        send_request(make_request(FUNC_SPLAT, 4095, 4095, 24'hFFFFFF, 4096, 63), 0);
        send_request(make_request(FUNC_SPLAT, 1792, 1792, 24'h0000FF, 4096, 17), 0);
        send_request(read_request(63), 0);
        // unused code leaves the store alone and answers zero
        send_request(make_request(FUNC_UNUSED, $urandom, $urandom, 24'($urandom),
                                  $urandom, 63), 0);
        send_request(read_request(63), 0);
        // stack three splats on one pixel to drive it into saturation
        repeat (3)
            send_request(make_request(FUNC_SPLAT, 512, 512, 24'h80C0F0, 4096, 18), 0);
        send_request(read_request(18), 0);
        send_request(make_request(FUNC_CLEAR, $urandom, $urandom, 24'($urandom),
                                  $urandom, $urandom), 0);
        send_request(read_request(18), pick_gap());
    endtask

    // Registers at their extremes, plus writes to indexes with no register
    task automatic test_register_extremes();
        wait_drained();
        write_reg(4'd15, 12'hFFF);
        write_reg(4'd2, 12'($urandom));
        write_reg(REG_WEIGHT_THRESHOLD, 12'd0);
        write_reg(REG_FALLOFF_RATE, {2'b11, 10'd0});
        // no falloff: every pixel gets the full power as weight
        send_request(make_request(FUNC_CLEAR, 0, 0, 24'd0, 0, 0), 0);
        send_request(make_request(FUNC_SPLAT, 768, 768, 24'h102030, 2048, 0), 0);
        send_request(read_request(0), 0);
        send_request(read_request(63), 0);
        wait_drained();
        write_reg(REG_WEIGHT_THRESHOLD, 12'd4095);
        write_reg(REG_FALLOFF_RATE, 12'hFFF);
        // steepest falloff and top threshold: only the centre pixel passes
        send_request(make_request(FUNC_SPLAT, 1024, 1024, 24'hFFFFFF, 8191, 0), 0);
        send_request(read_request(36), 0);
        send_request(read_request(37), 0);
        load_settings(THRESHOLD_RESET, FALLOFF_RESET);
        write_reg(4'd8, 12'($urandom));
    endtask

    // Hold the response side off for a long stretch while requests keep coming,
    // so the block fills up and stops taking requests
    task automatic test_receiver_backpressure();
        wait_drained();
        rsp_hold_left = 400;
        repeat (4)
            send_request(read_request($urandom_range(0, 63)), 0);
        send_request(random_request(), 0);
        repeat (5)
            send_request(read_request($urandom_range(0, 63)), 0);
        wait_drained();
    endtask

    // Pause the sender until the block has answered everything
    task automatic test_pause_until_drained();
        send_request(make_request(FUNC_SPLAT, 600, 1400, 24'($urandom), 3000, 0), 0);
        wait_drained();
        send_request(read_request(41), 0);
        send_request(read_request(42), 0);
        wait_drained();
    endtask

    // Random traffic under several register settings, extremes among them
    task automatic test_random_traffic();
        logic [11:0] thresholds [6];
        logic [9:0]  falloffs   [6];
        thresholds = '{12'd61, 12'd0,    12'd4095, 12'd0, 12'd4095, 12'($urandom)};
        falloffs   = '{10'd320, 10'd1023, 10'd0,   10'd0, 10'd1023, 10'($urandom)};
        for (int phase = 0; phase < 6; phase++)
        begin
            load_settings(thresholds[phase], falloffs[phase]);
            repeat (130)
                send_request(random_request(), pick_gap());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n             = 1'b0;
        req_valid         = 1'b0;
        func              = FUNC_CLEAR;
        center_x          = 13'sd0;
        center_y          = 13'sd0;
        color_rgb         = 24'd0;
        power             = 13'd0;
        pixel_index       = 6'd0;
        cfg_valid         = 1'b0;
        cfg_index         = REG_WEIGHT_THRESHOLD;
        cfg_data          = 12'd0;
        threshold_model   = THRESHOLD_RESET;
        falloff_model     = FALLOFF_RESET;
        mismatch_count    = 0;
        responses_checked = 0;
        splats_sent       = 0;
        reads_sent        = 0;
        clears_sent       = 0;
        unused_sent       = 0;
        reg_writes        = 0;
        cycle_count       = 0;
        rsp_hold_left     = 0;
        for (int i = 0; i < PIXELS; i++)
        begin
            frame_model[i] = 24'd0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed_ops();
        test_register_extremes();
        test_receiver_backpressure();
        test_pause_until_drained();
        test_random_traffic();

        // drain, then watch a little longer for stray responses
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d splats, %0d reads, %0d clears, %0d unused-code requests, %0d reg writes",
                 splats_sent, reads_sent, clears_sent, unused_sent, reg_writes);
        $display("Checked %0d responses against the predicted frame store", responses_checked);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== gaussian_glow_splat_framebuffer.f =====
rtl/ggsf_pkg.sv
rtl/ggsf_ram.sv
rtl/ggsf_mul.sv
rtl/gaussian_glow_splat_framebuffer.sv
tb/tb_gaussian_glow_splat_framebuffer.sv
